// ===== rtl/stepper_half_step_sequencer_macros.svh =====
// Assertion macros used by the checker file of the half-step sequencer.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH
`define STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHSQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shsq_pkg.sv =====
// Package of the half-step sequencer: item types, register codes, FSM types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package shsq_pkg;

    localparam int STEPS_W = 23;
    localparam int SPR_W   = 16;
    localparam int RPM_W   = 10;
    localparam int WRAP_W  = SPR_W + 1;
    localparam int PROD_W  = WRAP_W + RPM_W;
    localparam int QUOT_W  = 26;
    localparam int CNT_W   = 5;

    localparam logic [QUOT_W-1:0] US_PER_MINUTE = 26'd60000000;
    localparam logic [CNT_W-1:0]  DIV_LAST      = 5'(QUOT_W - 1);
    localparam logic [SPR_W-1:0]  SPR_RESET     = 16'd4096;
    localparam logic [RPM_W-1:0]  RPM_RESET     = 10'd10;
    localparam logic [WRAP_W-1:0] WRAP_ZERO_SPR = 17'h10000;

    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [0:0] {
        REG_STEPS_PER_REV = 1'b0,
        REG_SPEED_RPM     = 1'b1
    } reg_idx_t;

    typedef logic [3:0] coil_t;

    typedef struct packed {
        logic               req_type;
        logic signed [23:0] move_steps;
    } req_item_t;

    typedef struct packed {
        coil_t coils;
        logic  done_res;
    } res_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_MOVE,
        S_TICK
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul_load;
        logic div_step;
        logic move_commit;
        logic tick_advance;
        logic tick_fire;
    } cmd_t;

    typedef struct packed {
        logic in_is_tick;
        logic running;
        logic tick_expire;
        logic div_last;
        logic out_free;
    } sts_t;

    function automatic coil_t half_step(input logic [2:0] idx);
        coil_t c;
        case (idx)
            3'd0:    c = 4'b0001;
            3'd1:    c = 4'b0011;
            3'd2:    c = 4'b0010;
            3'd3:    c = 4'b0110;
            3'd4:    c = 4'b0100;
            3'd5:    c = 4'b1100;
            3'd6:    c = 4'b1000;
            3'd7:    c = 4'b1001;
            default: c = 4'b0000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stepper_half_step_sequencer.sv =====
// Top level of the half-step sequencer: APB register file, controller and datapath.
// Depends on shsq_pkg, shsq_ctrl and shsq_dp.
//
//   Port group   Handshake           Payload
//   req          req_valid/ready     req_item (req_type, move_steps)
//   res          res_valid/ready     res_item (coils, done_res)
//   cfg          psel/penable        paddr, pwdata, prdata (pready tied high)
//
// A tick item passes through S_TICK; a move item through S_MUL, S_DIV and S_MOVE, where
// the restoring divider retires one quotient bit per cycle over 26 bits.
// Reset clears all motion state and loads the register defaults; no clearing pass.
// A result waits in the output register; a later item that produces a result
// holds in its last state until that register is taken.
`default_nettype none

module stepper_half_step_sequencer #(
    parameter int INTERVAL_WIDTH = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    output logic                   req_ready,
    input  shsq_pkg::req_item_t    req_item,
    output logic                   res_valid,
    input  wire                    res_ready,
    output shsq_pkg::res_item_t    res_item,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [2:0]              paddr,
    input  wire [31:0]             pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import shsq_pkg::*;

    logic [SPR_W-1:0] spr_reg;
    logic [RPM_W-1:0] rpm_reg;
    reg_idx_t         reg_idx;
    cmd_t             cmd;
    sts_t             sts;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
            rpm_reg <= RPM_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                REG_STEPS_PER_REV: spr_reg <= pwdata[SPR_W-1:0];
                REG_SPEED_RPM:     rpm_reg <= pwdata[RPM_W-1:0];
                default:           spr_reg <= spr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STEPS_PER_REV: prdata = 32'(spr_reg);
            REG_SPEED_RPM:     prdata = 32'(rpm_reg);
            default:           prdata = '0;
        endcase
    end

    shsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    shsq_dp #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_item      (req_item),
        .steps_per_rev (spr_reg),
        .speed_rpm     (rpm_reg),
        .cmd           (cmd),
        .sts           (sts),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_item      (res_item)
    );

endmodule

`default_nettype wire

// ===== rtl/shsq_ctrl.sv =====
// Controller of the half-step sequencer: sequences item capture, divide, commit and ticks.
// Depends on shsq_pkg; drives shsq_dp through command and status structs.
`default_nettype none

module shsq_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_ready,
    input  shsq_pkg::sts_t    sts,
    output shsq_pkg::cmd_t    cmd
);
    import shsq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.in_is_tick ? S_TICK : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (!sts.running || !sts.tick_expire || sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_MOVE:
            begin
                cmd.move_commit = sts.out_free;
            end
            S_TICK:
            begin
                cmd.tick_advance = sts.running && !sts.tick_expire;
                cmd.tick_fire    = sts.running && sts.tick_expire && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/shsq_dp.sv =====
// Datapath of the half-step sequencer: restoring divider, motion state, result register.
// Depends on shsq_pkg; commanded by shsq_ctrl.
`default_nettype none

module shsq_dp #(
    parameter int INTERVAL_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  shsq_pkg::req_item_t                req_item,
    input  wire [shsq_pkg::SPR_W-1:0]          steps_per_rev,
    input  wire [shsq_pkg::RPM_W-1:0]          speed_rpm,
    input  shsq_pkg::cmd_t                     cmd,
    output shsq_pkg::sts_t                     sts,
    output logic                               res_valid,
    input  wire                                res_ready,
    output shsq_pkg::res_item_t                res_item
);
    import shsq_pkg::*;

    localparam logic [32:0] IMAX = (33'd1 << INTERVAL_WIDTH) - 33'd1;

    logic signed [23:0]        steps_in_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         rem_reg;
    logic [PROD_W-1:0]         rem_next;
    logic [QUOT_W-1:0]         quot_reg;
    logic [QUOT_W-1:0]         quot_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [INTERVAL_WIDTH-1:0] tick_reg;
    logic [INTERVAL_WIDTH-1:0] interval_reg;
    logic [INTERVAL_WIDTH-1:0] interval_next;
    logic [STEPS_W-1:0]        steps_reg;
    logic [SPR_W-1:0]          pos_reg;
    logic [SPR_W-1:0]          pos_next;
    logic                      fwd_reg;
    logic                      run_reg;
    logic                      out_valid_reg;
    res_item_t                 out_reg;

    logic [WRAP_W-1:0]         wrap;
    logic [PROD_W:0]           rem_shift;
    logic [INTERVAL_WIDTH-1:0] tick_inc;
    logic [WRAP_W-1:0]         pos_inc;
    logic [32:0]               quot_wide;

    assign wrap      = (steps_per_rev == '0) ? WRAP_ZERO_SPR : {1'b0, steps_per_rev};
    assign rem_shift = {rem_reg, quot_reg[QUOT_W-1]};
    assign tick_inc  = tick_reg + 1'b1;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign quot_wide = 33'(quot_reg);

    always_comb
    begin
        if (rem_shift >= {1'b0, prod_reg})
        begin
            rem_next  = PROD_W'(rem_shift - {1'b0, prod_reg});
            quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift[PROD_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        if (speed_rpm == '0 || quot_wide > IMAX)
        begin
            interval_next = INTERVAL_WIDTH'(IMAX);
        end
        else if (quot_reg == '0)
        begin
            interval_next = INTERVAL_WIDTH'(1);
        end
        else
        begin
            interval_next = INTERVAL_WIDTH'(quot_wide);
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            pos_next = (pos_inc >= wrap) ? '0 : pos_inc[SPR_W-1:0];
        end
        else if (pos_reg == '0)
        begin
            pos_next = SPR_W'(wrap - 1'b1);
        end
        else
        begin
            pos_next = pos_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            steps_in_reg <= req_item.move_steps;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(wrap) * PROD_W'(speed_rpm);
            rem_reg  <= '0;
            quot_reg <= US_PER_MINUTE;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (cmd.move_commit || cmd.tick_fire)
        begin
            if (cmd.tick_fire && steps_reg != '0)
            begin
                out_reg.coils <= half_step(pos_next[2:0]);
            end
            else
            begin
                out_reg.coils <= '0;
            end
            out_reg.done_res <= cmd.tick_fire && steps_reg == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            tick_reg      <= '0;
            interval_reg  <= INTERVAL_WIDTH'(1);
            steps_reg     <= '0;
            pos_reg       <= '0;
            fwd_reg       <= 1'b0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mul_load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.move_commit)
            begin
                steps_reg    <= (steps_in_reg[23] && steps_in_reg[22:0] == '0)
                                ? {STEPS_W{1'b1}}
                                : STEPS_W'(steps_in_reg[23] ? -steps_in_reg : steps_in_reg);
                fwd_reg      <= !steps_in_reg[23] && steps_in_reg != '0;
                pos_reg      <= '0;
                tick_reg     <= '0;
                interval_reg <= interval_next;
                run_reg      <= 1'b1;
            end
            else if (cmd.tick_advance)
            begin
                tick_reg <= tick_inc;
            end
            else if (cmd.tick_fire)
            begin
                tick_reg <= '0;
                if (steps_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    steps_reg <= steps_reg - 1'b1;
                end
            end

            if (cmd.move_commit || cmd.tick_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.in_is_tick  = (req_item.req_type == REQ_TICK);
    assign sts.running     = run_reg;
    assign sts.tick_expire = tick_inc >= interval_reg;
    assign sts.div_last    = cnt_reg == DIV_LAST;
    assign sts.out_free    = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/shsq_checker.sv =====
// Port-level checker of the half-step sequencer and its bind to the top level.
// Depends on shsq_pkg and stepper_half_step_sequencer_macros.svh.
`default_nettype none

`include "stepper_half_step_sequencer_macros.svh"

module shsq_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    req_valid,
    input wire                    req_ready,
    input shsq_pkg::req_item_t    req_item,
    input wire                    res_valid,
    input wire                    res_ready,
    input shsq_pkg::res_item_t    res_item
);
    import shsq_pkg::*;

    `SHSQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item), "Result item changed while stalled.")
    `SHSQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "Block took an item in the cycle after one was accepted.")
    `SHSQ_ASSERT_SAME(a_done_coils_off, res_valid && res_item.done_res, res_item.coils == 4'd0, "Finish item drives a coil.")
    `SHSQ_ASSERT_SAME(a_coil_pattern, res_valid, $countones(res_item.coils) <= 2, "More than two coils driven.")

endmodule

bind stepper_half_step_sequencer shsq_checker u_shsq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);

`default_nettype wire
